[hdl/assert_macros.svh]
// Assertion macros used by the verification file of the parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dotip_pkg.sv]
// Package with character codes, token kinds and the token type of the parser.
package dotip_pkg;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_DOT   = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Largest value of one part; the running value times ten plus a digit fits 12 bits.
    localparam logic [11:0] PART_MAX = 12'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] digit;
    } token_t;

endpackage

[hdl/dotip_ifs.sv]
// Handshake interfaces for the character channel and the result channel.
interface dotip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

interface dotip_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] address;

    modport source (output valid, output valid_res, output address, input ready);
    modport sink (input valid, input valid_res, input address, output ready);
endinterface

[hdl/dotip_front.sv]
// Front end: accepts characters and classifies each into a token for the queue.
module dotip_front (
    dotip_char_if.sink        chars,
    input  logic              full,
    output logic              push,
    output dotip_pkg::token_t token
);

    assign chars.ready = !full;
    assign push        = chars.valid && !full;

    always_comb
    begin
        // The low nibble of an ASCII digit is its value.
        token.digit = chars.character[3:0];
        if (chars.character inside {[dotip_pkg::CHAR_ZERO:dotip_pkg::CHAR_NINE]})
        begin
            token.kind = dotip_pkg::KIND_DIGIT;
        end
        else if (chars.character == dotip_pkg::CHAR_DOT)
        begin
            token.kind = dotip_pkg::KIND_DOT;
        end
        else if (chars.character == dotip_pkg::CHAR_NUL)
        begin
            token.kind = dotip_pkg::KIND_END;
        end
        else
        begin
            token.kind = dotip_pkg::KIND_OTHER;
        end
    end

endmodule

[hdl/dotip_queue.sv]
// Small first-in first-out queue of tokens between the front and back ends.
module dotip_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dotip_pkg::token_t push_token,
    output logic              full,
    input  logic              pop,
    output dotip_pkg::token_t pop_token,
    output logic              not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    dotip_pkg::token_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_token = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

[hdl/dotip_back.sv]
// Back end: runs the part parser on tokens and holds the result word.
module dotip_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  dotip_pkg::token_t token,
    output logic              tok_take,
    dotip_res_if.source       results
);

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_DIGITS = 2'd1;
    localparam logic [1:0] MODE_FAILED = 2'd2;

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  third_reg, third_next;
    logic        res_valid_reg, res_valid_next;
    logic        res_flag_reg, res_flag_next;
    logic [31:0] res_addr_reg, res_addr_next;
    logic [11:0] grown;
    logic [2:0]  parts;
    logic [31:0] composed;

    // A terminator needs a free result register; every other token goes straight in.
    assign tok_take = tok_valid
        && ((token.kind != dotip_pkg::KIND_END) || !res_valid_reg || results.ready);

    assign results.valid     = res_valid_reg;
    assign results.valid_res = res_flag_reg;
    assign results.address   = res_addr_reg;

    // Running value times ten plus the new digit.
    assign grown = 12'({cur_reg, 3'b000}) + 12'({cur_reg, 1'b0}) + 12'(token.digit);

    always_comb
    begin
        case (mode_reg)
            MODE_DIGITS: parts = count_reg + 3'd1;
            MODE_START:  parts = count_reg;
            default:     parts = 3'd0;
        endcase
        case (parts)
            3'd1:    composed = {24'd0, cur_reg};
            3'd2:    composed = {first_reg, 16'd0, cur_reg};
            3'd3:    composed = {first_reg, second_reg, 8'd0, cur_reg};
            default: composed = {first_reg, second_reg, third_reg, cur_reg};
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        res_valid_next = res_valid_reg && !results.ready;
        res_flag_next  = res_flag_reg;
        res_addr_next  = res_addr_reg;

        if (tok_take)
        begin
            if (token.kind == dotip_pkg::KIND_END)
            begin
                res_valid_next = 1'b1;
                if ((parts != 3'd0) && (parts <= 3'd4))
                begin
                    res_flag_next = 1'b1;
                    res_addr_next = composed;
                end
                else
                begin
                    res_flag_next = 1'b0;
                    res_addr_next = '0;
                end
                mode_next   = MODE_START;
                count_next  = '0;
                cur_next    = '0;
                first_next  = '0;
                second_next = '0;
                third_next  = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_START:
                    begin
                        if ((token.kind == dotip_pkg::KIND_DIGIT) && (count_reg < 3'd4))
                        begin
                            cur_next  = 8'(token.digit);
                            mode_next = MODE_DIGITS;
                        end
                        else
                        begin
                            mode_next = MODE_FAILED;
                        end
                    end
                    MODE_DIGITS:
                    begin
                        if (token.kind == dotip_pkg::KIND_DIGIT)
                        begin
                            if (grown > dotip_pkg::PART_MAX)
                            begin
                                mode_next = MODE_FAILED;
                            end
                            else
                            begin
                                cur_next = grown[7:0];
                            end
                        end
                        else if ((token.kind == dotip_pkg::KIND_DOT) && (count_reg < 3'd4))
                        begin
                            case (count_reg)
                                3'd0:    first_next  = cur_reg;
                                3'd1:    second_next = cur_reg;
                                3'd2:    third_next  = cur_reg;
                                default: ;
                            endcase
                            count_next = count_reg + 3'd1;
                            mode_next  = MODE_START;
                        end
                        else
                        begin
                            mode_next = MODE_FAILED;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_FAILED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            count_reg     <= '0;
            cur_reg       <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            third_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_flag_reg <= res_flag_next;
        res_addr_reg <= res_addr_next;
    end

endmodule

[hdl/dotted_decimal_ipv4_parser.sv]
// Top level of the dotted-decimal IPv4 address parser.
//
// The parser takes a string one character word at a time on chars and sends one
// result word on results for every zero character, which ends the string. The
// result carries valid_res and a 32-bit address with the first part in the top
// byte; byte-swapping to network order is left to the integration. One to four
// decimal parts separated by dots are accepted, each at most 255, with short
// forms filled as 0.0.0.N, a.0.0.b and a.b.0.c, and one trailing dot allowed.
// Empty parts, extra parts, other characters and the empty string give
// valid_res low and a zero address; after a failure characters are ignored
// up to the terminator. Leading zeros read as decimal; there are no hex or octal
// forms. The block sustains one character per cycle while no stalled result
// holds back a terminator. A front end classifies each accepted character and
// writes it into a token queue of QUEUE_DEPTH entries; a back end takes one
// token per cycle unless a terminator waits on a stalled result, and updates
// the running part value with a multiply by ten and a compare against 255 in
// the same cycle as it takes the digit. The terminator is written into the
// queue, and results.valid rises in the cycle after the back end takes it. The
// result sits in an output register, so a stalled result channel holds only
// the back end's next terminator; the queue keeps taking characters until it
// fills, and chars.ready then drops.
module dotted_decimal_ipv4_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    dotip_char_if.sink   chars,
    dotip_res_if.source  results
);

    dotip_pkg::token_t front_token;
    dotip_pkg::token_t back_token;
    logic              push;
    logic              full;
    logic              tok_valid;
    logic              tok_take;

    // Classification and acceptance of incoming characters.
    dotip_front u_front (
        .chars (chars),
        .full  (full),
        .push  (push),
        .token (front_token)
    );

    // Token queue that lets the input side and the result side stall apart.
    dotip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (front_token),
        .full       (full),
        .pop        (tok_take),
        .pop_token  (back_token),
        .not_empty  (tok_valid)
    );

    // Part parser and the result register.
    dotip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .token     (back_token),
        .tok_take  (tok_take),
        .results   (results)
    );

endmodule

[hdl/dotip_checker.sv]
// Port-level checker for the parser and the bind that attaches it.
`include "assert_macros.svh"

module dotip_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  character,
    input logic        res_valid,
    input logic        res_ready,
    input logic        valid_res,
    input logic [31:0] address
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       term_in;
    logic       res_out;

    assign term_in = in_valid && in_ready && (character == dotip_pkg::CHAR_NUL);
    assign res_out = res_valid && res_ready;

    // Terminators accepted whose result words are not yet delivered.
    always_comb
    begin
        pend_next = pend_reg;
        if (term_in && !res_out)
        begin
            pend_next = pend_reg + 8'd1;
        end
        else if (res_out && !term_in)
        begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `ASSERT_NEXT(a_res_held, clk, rst_n, res_valid && !res_ready, res_valid, "result word dropped while stalled")
    `ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(address) && $stable(valid_res), "result word changed while stalled")
    `ASSERT_CLK(a_reject_zero, clk, rst_n, !(res_valid && !valid_res) || (address == 32'd0), "rejected string carries a nonzero address")
    `ASSERT_CLK(a_res_has_term, clk, rst_n, !res_valid || (pend_reg != 8'd0), "result word without an accepted terminator")

endmodule

bind dotted_decimal_ipv4_parser dotip_checker u_dotip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .character (chars.character),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .valid_res (results.valid_res),
    .address   (results.address)
);
